[rtl/i2p_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Types, character and status codes and operator ranks for the infix to postfix converter.
package i2p_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int CHAR_W          = 8;
	localparam int STATUS_W        = 2;

	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_POW    = 8'h5E;
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNMATCHED = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_EVAL,
		ST_END
	} i2p_state_t;

	typedef enum logic [1:0] {
		MODE_CLOSE,
		MODE_OP,
		MODE_FLUSH
	} i2p_mode_t;

	function automatic logic [1:0] op_rank(input logic [CHAR_W-1:0] c);
		logic [1:0] r;
		unique case (c)
			CH_PLUS, CH_MINUS: r = 2'd1;
			CH_MUL, CH_DIV:    r = 2'd2;
			CH_POW:            r = 2'd3;
			default:           r = 2'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/infix_to_postfix_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Infix to postfix converter: sequencer around an operator stack memory.
//
//  channel  | dir | fields
//  s_axis   | in  | tdata[7:0] in_char, tlast end_of_expr
//  m_axis   | out | tdata[7:0] out_char, tuser[0] char_valid, tuser[2:1] status, tlast last
//
// A plain character or '(' passes through the decode and end states before the next acceptance.
// ')' and an operator add a memory read and then a compare for each stack entry examined,
// plus one more read step when the stack runs empty. The end of an expression adds a
// read and a compare for each entry flushed, plus a final read step. The registered
// stack read port sets these steps.
// Reset empties the stack at once; no sweep of the memory is needed.
// A stalled m_axis request holds the sequencer; s_axis takes a request only
// when the previous one has been fully worked off.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [i2p_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] in_char
	input  wire logic                        s_axis_tlast,   // end_of_expr
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [i2p_pkg::CHAR_W-1:0]       m_axis_tdata,   // [7:0] out_char
	output logic [i2p_pkg::STATUS_W:0]       m_axis_tuser,   // [0] char_valid, [2:1] status
	output logic                             m_axis_tlast    // last
);
	import i2p_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	i2p_state_t state_q, state_d;
	i2p_mode_t  mode_q, mode_d;
	logic [CW-1:0] count_q, count_d;
	logic          emitted_q, emitted_d;
	logic [CHAR_W-1:0] ch_q;
	logic          end_q;

	logic [CHAR_W-1:0] mem [STACK_DEPTH];
	logic [CHAR_W-1:0] rd_data_q;
	logic [CHAR_W-1:0] rd_next_q;
	logic          wr_en, rd_en;

	logic              out_free;
	logic              emit;
	logic [CHAR_W-1:0] emit_char;
	logic              emit_valid;
	logic              emit_last;
	logic [STATUS_W-1:0] emit_status;
	logic              full;
	logic              pop_ok;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign full          = (count_q == FULL);
	assign pop_ok        = (op_rank(rd_data_q) >= op_rank(ch_q));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(count_q)] <= ch_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[AW'(count_q - 1'b1)];
			if (count_q >= CW'(2)) begin
				rd_next_q <= mem[AW'(count_q - CW'(2))];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_CLOSE;
			count_q   <= '0;
			emitted_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			count_q   <= count_d;
			emitted_q <= emitted_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_q  <= s_axis_tdata;
			end_q <= s_axis_tlast;
		end
	end

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		count_d     = count_q;
		emitted_d   = emitted_q;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		emit        = 1'b0;
		emit_char   = ch_q;
		emit_valid  = 1'b1;
		emit_last   = 1'b0;
		emit_status = STATUS_OK;
		unique case (state_q)
			ST_IDLE: begin
				emitted_d = 1'b0;
				if (s_axis_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (out_free) begin
					priority if (ch_q == CH_LPAREN) begin
						state_d = ST_END;
						if (full) begin
							emit        = 1'b1;
							emit_valid  = 1'b0;
							emit_status = STATUS_OVERFLOW;
						end else begin
							wr_en   = 1'b1;
							count_d = count_q + 1'b1;
						end
					end else if (ch_q == CH_RPAREN) begin
						mode_d  = MODE_CLOSE;
						state_d = ST_READ;
					end else if (op_rank(ch_q) != 2'd0) begin
						mode_d  = MODE_OP;
						state_d = ST_READ;
					end else begin
						emit      = 1'b1;
						emit_last = end_q && (count_q == '0);
						state_d   = ST_END;
					end
				end
			end
			ST_READ: begin
				if (out_free) begin
					if (count_q == '0) begin
						unique case (mode_q)
							MODE_CLOSE: begin
								emit        = 1'b1;
								emit_char   = CH_RPAREN;
								emit_valid  = 1'b0;
								emit_status = STATUS_UNMATCHED;
								emit_last   = end_q;
								state_d     = ST_END;
							end
							MODE_OP: begin
								wr_en   = 1'b1;
								count_d = count_q + 1'b1;
								state_d = ST_END;
							end
							default: begin
								if (!emitted_q) begin
									emit       = 1'b1;
									emit_char  = CH_NUL;
									emit_valid = 1'b0;
									emit_last  = 1'b1;
								end
								state_d = ST_IDLE;
							end
						endcase
					end else begin
						rd_en   = 1'b1;
						state_d = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				if (out_free) begin
					unique case (mode_q)
						MODE_CLOSE: begin
							count_d = count_q - 1'b1;
							if (rd_data_q == CH_LPAREN) begin
								state_d = ST_END;
							end else begin
								emit      = 1'b1;
								emit_char = rd_data_q;
								emit_last = end_q && (count_q == CW'(2)) &&
									(rd_next_q == CH_LPAREN);
								state_d   = ST_READ;
							end
						end
						MODE_OP: begin
							if (pop_ok) begin
								count_d   = count_q - 1'b1;
								emit      = 1'b1;
								emit_char = rd_data_q;
								state_d   = ST_READ;
							end else if (full) begin
								emit        = 1'b1;
								emit_valid  = 1'b0;
								emit_status = STATUS_OVERFLOW;
								state_d     = ST_END;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + 1'b1;
								state_d = ST_END;
							end
						end
						default: begin
							count_d   = count_q - 1'b1;
							emit      = 1'b1;
							emit_char = rd_data_q;
							emit_last = (count_q == CW'(1));
							state_d   = ST_READ;
						end
					endcase
				end
			end
			ST_END: begin
				if (end_q) begin
					mode_d  = MODE_FLUSH;
					state_d = ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (emit) begin
			emitted_d = 1'b1;
		end
	end

	// hold the request until taken, reload as soon as it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata <= emit_char;
			m_axis_tuser <= {emit_status, emit_valid};
			m_axis_tlast <= emit_last;
		end
	end

endmodule
`default_nettype wire

[bench/infix_to_postfix_converter_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the infix to postfix converter: directed table, then random streams.
module infix_to_postfix_converter_tb;

	import i2p_pkg::*;

	localparam int DEPTH     = STACK_DEPTH_DEF;
	localparam int LIMIT     = 600000;
	localparam int PHASE_LEN = 117;
	localparam int DRAIN     = 100;

	localparam logic [CHAR_W-1:0] CH_A    = "a";
	localparam logic [CHAR_W-1:0] CH_ZERO = "0";

	typedef struct packed {
		logic [CHAR_W-1:0]   ch;
		logic                valid;
		logic                last;
		logic [STATUS_W-1:0] status;
	} post_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              eoe;
	} tok_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              eoe;
		logic              typed;
		post_t             want;
	} dir_row_t;

	localparam post_t NO_RES = '{CH_NUL, 1'b0, 1'b0, STATUS_OK};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [CHAR_W-1:0]   s_axis_tdata = '0;
	logic                s_axis_tlast = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [CHAR_W-1:0]   m_axis_tdata;
	logic [STATUS_W:0]   m_axis_tuser;
	logic                m_axis_tlast;

	logic [CHAR_W-1:0] pf_stack [DEPTH];
	int                pf_count = 0;
	post_t             step_out [$];
	post_t             postfix_q [$];
	tok_t              tok_q [$];

	int err_cnt      = 0;
	int cycles       = 0;
	int src_idle_pct = 10;
	int snk_idle_pct = 53;
	int hold_cnt     = 0;

	dir_row_t dir_tab [24] = '{
		'{CH_A,        1'b1, 1'b1, '{CH_A, 1'b1, 1'b1, STATUS_OK}},
		'{CH_NUL,      1'b0, 1'b1, '{CH_NUL, 1'b1, 1'b0, STATUS_OK}},
		'{8'hFF,       1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, STATUS_OK}},
		'{CH_RPAREN,   1'b0, 1'b1, '{CH_RPAREN, 1'b0, 1'b0, STATUS_UNMATCHED}},
		'{CH_LPAREN,   1'b0, 1'b0, NO_RES},
		'{CH_RPAREN,   1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, STATUS_OK}},
		'{CH_A,        1'b0, 1'b0, NO_RES},
		'{CH_PLUS,     1'b0, 1'b0, NO_RES},
		'{CH_A + 8'd1, 1'b0, 1'b0, NO_RES},
		'{CH_MUL,      1'b0, 1'b0, NO_RES},
		'{CH_A + 8'd2, 1'b0, 1'b0, NO_RES},
		'{CH_POW,      1'b0, 1'b0, NO_RES},
		'{CH_A + 8'd3, 1'b0, 1'b0, NO_RES},
		'{CH_POW,      1'b0, 1'b0, NO_RES},
		'{CH_A + 8'd4, 1'b0, 1'b0, NO_RES},
		'{CH_MINUS,    1'b0, 1'b0, NO_RES},
		'{CH_LPAREN,   1'b0, 1'b0, NO_RES},
		'{CH_A + 8'd5, 1'b0, 1'b0, NO_RES},
		'{CH_DIV,      1'b0, 1'b0, NO_RES},
		'{CH_A + 8'd6, 1'b0, 1'b0, NO_RES},
		'{CH_RPAREN,   1'b0, 1'b0, NO_RES},
		'{CH_LPAREN,   1'b0, 1'b0, NO_RES},
		'{CH_A + 8'd7, 1'b1, 1'b0, NO_RES},
		'{CH_RPAREN,   1'b1, 1'b1, '{CH_RPAREN, 1'b0, 1'b1, STATUS_UNMATCHED}}
	};

	infix_to_postfix_converter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int prec_of(input logic [CHAR_W-1:0] c);
		case (c)
			CH_PLUS, CH_MINUS: return 1;
			CH_MUL, CH_DIV:    return 2;
			CH_POW:            return 3;
			default:           return 0;
		endcase
	endfunction

	function automatic void add_out(input logic [CHAR_W-1:0] c, input logic v,
			input logic [STATUS_W-1:0] st);
		step_out.push_back(post_t'{c, v, 1'b0, st});
	endfunction

	function automatic void push_op(input logic [CHAR_W-1:0] c);
		if (pf_count >= DEPTH) begin
			add_out(c, 1'b0, STATUS_OVERFLOW);
		end else begin
			pf_stack[pf_count] = c;
			pf_count++;
		end
	endfunction

	function automatic void convert_char(input logic [CHAR_W-1:0] c, input logic eoe);
		logic  found;
		post_t tail;
		step_out.delete();
		if (c == CH_LPAREN) begin
			push_op(c);
		end else if (c == CH_RPAREN) begin
			found = 1'b0;
			while (pf_count > 0 && !found) begin
				pf_count--;
				if (pf_stack[pf_count] == CH_LPAREN)
					found = 1'b1;
				else
					add_out(pf_stack[pf_count], 1'b1, STATUS_OK);
			end
			if (!found)
				add_out(CH_RPAREN, 1'b0, STATUS_UNMATCHED);
		end else if (prec_of(c) != 0) begin
			while (pf_count > 0 && prec_of(pf_stack[pf_count-1]) >= prec_of(c)) begin
				pf_count--;
				add_out(pf_stack[pf_count], 1'b1, STATUS_OK);
			end
			push_op(c);
		end else begin
			add_out(c, 1'b1, STATUS_OK);
		end
		if (eoe) begin
			while (pf_count > 0) begin
				pf_count--;
				add_out(pf_stack[pf_count], 1'b1, STATUS_OK);
			end
			if (step_out.size() == 0)
				add_out(CH_NUL, 1'b0, STATUS_OK);
			tail = step_out.pop_back();
			tail.last = 1'b1;
			step_out.push_back(tail);
		end
	endfunction

	function automatic logic [CHAR_W-1:0] rand_operand();
		if ($urandom_range(1))
			return CH_A + 8'($urandom_range(25));
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_op();
		case ($urandom_range(4))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_MUL;
			3:       return CH_DIV;
			default: return CH_POW;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] rand_byte();
		if ($urandom_range(9) >= 4)
			return 8'($urandom_range(255));
		case ($urandom_range(6))
			0:       return CH_LPAREN;
			1:       return CH_RPAREN;
			default: return rand_op();
		endcase
	endfunction

	function automatic void add_tok(input logic [CHAR_W-1:0] c, input logic eoe);
		tok_q.push_back(tok_t'{c, eoe});
	endfunction

	function automatic void gen_expr();
		int   terms, depth, k;
		tok_t t;
		terms = $urandom_range(1, 8);
		depth = 0;
		for (k = 0; k < terms; k++) begin
			while ($urandom_range(3) == 0) begin
				add_tok(CH_LPAREN, 1'b0);
				depth++;
			end
			add_tok(rand_operand(), 1'b0);
			while (depth > 0 && $urandom_range(2) == 0) begin
				add_tok(CH_RPAREN, 1'b0);
				depth--;
			end
			if (k < terms - 1)
				add_tok(rand_op(), 1'b0);
		end
		while (depth > 0) begin
			add_tok(CH_RPAREN, 1'b0);
			depth--;
		end
		t = tok_q.pop_back();
		t.eoe = 1'b1;
		tok_q.push_back(t);
	endfunction

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic eoe, input logic typed,
			input post_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eoe;
		do @(posedge clk); while (!s_axis_tready);
		convert_char(c, eoe);
		if (typed) begin
			postfix_q.push_back(want);
		end else begin
			foreach (step_out[i])
				postfix_q.push_back(step_out[i]);
		end
		@(negedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				m_axis_tready <= 1'b0;
				hold_cnt--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		post_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[2:1]};
			if (postfix_q.size() == 0) begin
				$error("unexpected request: out_char %h char_valid %b last %b status %0d",
					got.ch, got.valid, got.last, got.status);
				err_cnt++;
			end else begin
				want = postfix_q.pop_front();
				if (got.ch !== want.ch) begin
					$error("out_char: expected %h, got %h", want.ch, got.ch);
					err_cnt++;
				end
				if (got.valid !== want.valid) begin
					$error("char_valid: expected %b, got %b", want.valid, got.valid);
					err_cnt++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, got.last);
					err_cnt++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		tok_t t;
		int   p, sent, n, k;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_tab[i])
			send_char(dir_tab[i].ch, dir_tab[i].eoe, dir_tab[i].typed, dir_tab[i].want);
		for (p = 0; p < 3; p++) begin
			src_idle_pct = (p == 0) ? 10 : (p == 1) ? 53 : 0;
			snk_idle_pct = (p == 0) ? 53 : (p == 1) ? 10 : 0;
			if (p == 2)
				hold_cnt = 300;
			sent = 0;
			while (sent < PHASE_LEN) begin
				case ($urandom_range(19))
					0, 1, 2: begin
						n = $urandom_range(14, 20);
						for (k = 0; k < n; k++) begin
							add_tok(CH_LPAREN, 1'b0);
							add_tok(rand_op(), 1'b0);
						end
						add_tok(rand_operand(), 1'b0);
						for (k = $urandom_range(n); k > 0; k--)
							add_tok(CH_RPAREN, 1'b0);
						add_tok(rand_operand(), 1'b1);
					end
					3, 4, 5: begin
						gen_expr();
						k = $urandom_range(tok_q.size() - 1);
						t = tok_q[k];
						case ($urandom_range(2))
							0: begin
								t.ch = rand_byte();
								tok_q[k] = t;
							end
							1: tok_q.insert(k, tok_t'{CH_RPAREN, 1'b0});
							default: begin
								t = tok_q.pop_back();
								t.eoe = 1'b0;
								tok_q.push_back(t);
							end
						endcase
					end
					6, 7, 8: begin
						for (k = $urandom_range(1, 6); k > 0; k--)
							add_tok(rand_byte(), $urandom_range(99) < 15);
					end
					default: gen_expr();
				endcase
				while (tok_q.size() != 0) begin
					t = tok_q.pop_front();
					send_char(t.ch, t.eoe, 1'b0, NO_RES);
					sent++;
				end
			end
		end
		s_axis_tvalid <= 1'b0;
		while (postfix_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
rtl/i2p_pkg.sv
rtl/infix_to_postfix_converter.sv
bench/infix_to_postfix_converter_tb.sv
